### rtl/sem_pkg.sv
// sem_pkg: shared types and constants for the Sobel edge magnitude block.
// Holds the controller state enum, the command struct and the datapath constants.
// No dependencies.
package sem_pkg;

  localparam int unsigned MAX_WIDTH_DEF  = 2048;
  localparam int unsigned MAX_HEIGHT_DEF = 4096;

  localparam int unsigned COL_W  = 11;
  localparam int unsigned ROW_W  = 12;
  localparam int unsigned WCFG_W = 12;
  localparam int unsigned HCFG_W = 13;
  localparam int unsigned CFG_W  = 13;

  // configuration register indexes
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // luma coefficients, 16-bit fixed point
  localparam logic [15:0] COEF_B = 16'd7471;
  localparam logic [15:0] COEF_G = 16'd38470;
  localparam logic [15:0] COEF_R = 16'd19595;
  localparam logic [24:0] LUMA_RND = 25'd32768;

  // root: sum of squares stays below 2^22, so 11 digit steps
  localparam int unsigned SQ_W       = 22;
  localparam int unsigned ROOT_STEPS = 11;
  localparam logic [SQ_W-1:0] ROOT_BIT0 = 22'h100000;

  // emit slots
  localparam logic [1:0] SLOT_MAIN  = 2'd0;
  localparam logic [1:0] SLOT_RIGHT = 2'd1;
  localparam logic [1:0] SLOT_BOT   = 2'd2;
  localparam logic [1:0] SLOT_LAST  = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LUMA,
    ST_GRAD,
    ST_SQX,
    ST_SQY,
    ST_ROOT,
    ST_EMIT
  } sem_state_e;

  typedef struct packed {
    logic       capture;
    logic       do_luma;
    logic       do_grad;
    logic       do_sqx;
    logic       do_sqy;
    logic       root_step;
    logic [1:0] slot;
  } sem_cmd_t;

endpackage

### rtl/sem_ctrl.sv
// sem_ctrl: controller state machine for the Sobel edge magnitude block.
// Sequences capture, luma, gradient, square, root and emit steps.
// Depends on sem_pkg.
module sem_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              out_ready_i,
  input  logic [3:0]        emit_flags_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  output sem_pkg::sem_cmd_t cmd_o
);

  sem_pkg::sem_state_e state_q, state_d;
  logic [3:0] iter_q, iter_d;
  logic [1:0] slot_q, slot_d;
  logic       slot_done;

  // a slot is finished when it emits nothing or its transfer completes
  assign slot_done = !emit_flags_i[slot_q] || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sem_pkg::ST_IDLE: if (in_valid_i) state_d = sem_pkg::ST_LUMA;
      sem_pkg::ST_LUMA: state_d = sem_pkg::ST_GRAD;
      sem_pkg::ST_GRAD: state_d = sem_pkg::ST_SQX;
      sem_pkg::ST_SQX:  state_d = sem_pkg::ST_SQY;
      sem_pkg::ST_SQY:  state_d = sem_pkg::ST_ROOT;
      sem_pkg::ST_ROOT: begin
        if (iter_q == 4'(sem_pkg::ROOT_STEPS - 1)) state_d = sem_pkg::ST_EMIT;
      end
      sem_pkg::ST_EMIT: begin
        if (slot_done && slot_q == sem_pkg::SLOT_LAST) state_d = sem_pkg::ST_IDLE;
      end
      default: state_d = sem_pkg::ST_IDLE;
    endcase
  end

  // counters for root steps and emit slots
  always_comb begin
    iter_d = iter_q;
    slot_d = slot_q;
    if (state_q == sem_pkg::ST_SQY) iter_d = '0;
    else if (state_q == sem_pkg::ST_ROOT) iter_d = iter_q + 4'd1;
    if (state_q == sem_pkg::ST_ROOT) slot_d = sem_pkg::SLOT_MAIN;
    else if (state_q == sem_pkg::ST_EMIT && slot_done) slot_d = slot_q + 2'd1;
  end

  // outputs
  always_comb begin
    cmd_o       = '0;
    cmd_o.slot  = slot_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      sem_pkg::ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      sem_pkg::ST_LUMA: cmd_o.do_luma   = 1'b1;
      sem_pkg::ST_GRAD: cmd_o.do_grad   = 1'b1;
      sem_pkg::ST_SQX:  cmd_o.do_sqx    = 1'b1;
      sem_pkg::ST_SQY:  cmd_o.do_sqy    = 1'b1;
      sem_pkg::ST_ROOT: cmd_o.root_step = 1'b1;
      sem_pkg::ST_EMIT: out_valid_o     = emit_flags_i[slot_q];
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sem_pkg::ST_IDLE;
      iter_q  <= '0;
      slot_q  <= '0;
    end else begin
      state_q <= state_d;
      iter_q  <= iter_d;
      slot_q  <= slot_d;
    end
  end

  // checks
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o) else $error("input taken while result pending");
  a_accept_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> state_q == sem_pkg::ST_LUMA)
    else $error("transfer did not start processing");
  a_root_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == sem_pkg::ST_ROOT |-> iter_q < 4'(sem_pkg::ROOT_STEPS))
    else $error("root step count overrun");
  a_emit_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sem_pkg::ST_EMIT && slot_q == sem_pkg::SLOT_LAST && slot_done)
    |=> state_q == sem_pkg::ST_IDLE) else $error("emit did not finish");

endmodule

### rtl/sem_datapath.sv
// sem_datapath: line store, window, luma, Sobel sums, digit-serial root and
// result selection for the Sobel edge magnitude block. Depends on sem_pkg.
module sem_datapath #(
  parameter int unsigned MAX_WIDTH  = sem_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = sem_pkg::MAX_HEIGHT_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic                       cfg_idx_i,
  input  logic [sem_pkg::CFG_W-1:0]  cfg_wdata_i,
  input  logic [7:0]                 blue_i,
  input  logic [7:0]                 green_i,
  input  logic [7:0]                 red_i,
  input  sem_pkg::sem_cmd_t          cmd_i,
  output logic [3:0]                 emit_flags_o,
  output logic [sem_pkg::COL_W-1:0]  out_col_o,
  output logic [sem_pkg::ROW_W-1:0]  out_row_o,
  output logic [7:0]                 edge_res_o,
  output logic                       last_o
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned RW = $clog2(MAX_HEIGHT);
  localparam int unsigned SW = sem_pkg::SQ_W;

  logic [sem_pkg::WCFG_W-1:0] width_q;
  logic [sem_pkg::HCFG_W-1:0] height_q;
  logic [31:0] w_sel, h_sel;
  logic [CW-1:0] wm1;
  logic [RW-1:0] hm1;

  logic [CW-1:0] col_cnt_q, c_q;
  logic [RW-1:0] row_cnt_q, r_q;
  logic          eor, last_row, mag_ok_q;
  logic [3:0]    flags_q;
  logic [7:0]    b_q, g_q, rd_q;
  logic [15:0]   line_mem [MAX_WIDTH];
  logic [15:0]   rdata_q;
  logic [7:0]    luma_q;
  logic [24:0]   luma_sum;
  logic [7:0]    win_q [6];
  logic [7:0]    top, mid;
  logic signed [11:0] gx, gy;
  logic [9:0]    ax_q, ay_q;
  logic [SW-1:0] sqx_q, rem_q, res_q, bit_q, trial;
  logic [SW-1:0] res_rnd;
  logic [7:0]    mag;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= sem_pkg::WCFG_W'(640);
      height_q <= sem_pkg::HCFG_W'(480);
    end else if (cfg_we_i) begin
      if (cfg_idx_i == sem_pkg::REG_WIDTH) width_q <= cfg_wdata_i[sem_pkg::WCFG_W-1:0];
      else height_q <= cfg_wdata_i;
    end
  end

  // saturated frame size
  always_comb begin
    w_sel = 32'(width_q);
    if (w_sel < 32'd3) w_sel = 32'd3;
    else if (w_sel > 32'(MAX_WIDTH)) w_sel = 32'(MAX_WIDTH);
    h_sel = 32'(height_q);
    if (h_sel < 32'd3) h_sel = 32'd3;
    else if (h_sel > 32'(MAX_HEIGHT)) h_sel = 32'(MAX_HEIGHT);
  end
  assign wm1      = CW'(w_sel - 32'd1);
  assign hm1      = RW'(h_sel - 32'd1);
  assign eor      = col_cnt_q >= wm1;
  assign last_row = row_cnt_q >= hm1;

  // capture item, position and emit plan; advance raster counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_cnt_q <= '0;
      row_cnt_q <= '0;
      flags_q   <= '0;
    end else if (cmd_i.capture) begin
      flags_q[0] <= row_cnt_q != '0 && col_cnt_q != '0;
      flags_q[1] <= row_cnt_q != '0 && eor;
      flags_q[2] <= row_cnt_q != '0 && last_row && col_cnt_q != '0;
      flags_q[3] <= row_cnt_q != '0 && last_row && eor;
      if (eor) begin
        col_cnt_q <= '0;
        row_cnt_q <= last_row ? '0 : row_cnt_q + RW'(1);
      end else begin
        col_cnt_q <= col_cnt_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      b_q      <= blue_i;
      g_q      <= green_i;
      rd_q     <= red_i;
      c_q      <= col_cnt_q;
      r_q      <= row_cnt_q;
      mag_ok_q <= row_cnt_q >= RW'(2) && col_cnt_q >= CW'(2)
                  && col_cnt_q <= wm1 && row_cnt_q <= hm1;
    end
  end
  assign emit_flags_o = flags_q;

  // line store: {older, newer} per column
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) rdata_q <= line_mem[col_cnt_q];
    if (cmd_i.do_grad) line_mem[c_q] <= {rdata_q[7:0], luma_q};
  end
  assign top = rdata_q[15:8];
  assign mid = rdata_q[7:0];

  // luma, products widened before the multiply
  assign luma_sum = 25'(b_q) * 25'(sem_pkg::COEF_B) + 25'(g_q) * 25'(sem_pkg::COEF_G)
                  + 25'(rd_q) * 25'(sem_pkg::COEF_R) + sem_pkg::LUMA_RND;
  always_ff @(posedge clk_i) begin
    if (cmd_i.do_luma) luma_q <= luma_sum[23:16];
  end

  // Sobel sums over the window
  assign gx = (12'(top) + 12'({mid, 1'b0}) + 12'(luma_q))
            - (12'(win_q[0]) + 12'({win_q[1], 1'b0}) + 12'(win_q[2]));
  assign gy = (12'(win_q[2]) + 12'({win_q[5], 1'b0}) + 12'(luma_q))
            - (12'(win_q[0]) + 12'({win_q[3], 1'b0}) + 12'(top));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) win_q[i] <= '0;
    end else if (cmd_i.do_grad) begin
      win_q[0] <= win_q[3];
      win_q[1] <= win_q[4];
      win_q[2] <= win_q[5];
      win_q[3] <= top;
      win_q[4] <= mid;
      win_q[5] <= luma_q;
    end
  end

  // magnitude: squares then a two-bits-per-step root
  assign trial = res_q + bit_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.do_grad) begin
      ax_q <= gx[11] ? 10'(-gx) : 10'(gx);
      ay_q <= gy[11] ? 10'(-gy) : 10'(gy);
    end
    if (cmd_i.do_sqx) sqx_q <= SW'(ax_q) * SW'(ax_q);
    if (cmd_i.do_sqy) begin
      rem_q <= sqx_q + SW'(ay_q) * SW'(ay_q);
      res_q <= '0;
      bit_q <= sem_pkg::ROOT_BIT0;
    end else if (cmd_i.root_step) begin
      if (rem_q >= trial) begin
        rem_q <= rem_q - trial;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  // round to nearest and clamp
  assign res_rnd = (rem_q > res_q) ? res_q + SW'(1) : res_q;
  assign mag     = (res_rnd > SW'(255)) ? 8'd255 : res_rnd[7:0];

  // result fields per emit slot
  always_comb begin
    out_col_o  = sem_pkg::COL_W'(c_q);
    out_row_o  = sem_pkg::ROW_W'(r_q);
    edge_res_o = '0;
    last_o     = 1'b0;
    case (cmd_i.slot)
      sem_pkg::SLOT_MAIN: begin
        out_col_o  = sem_pkg::COL_W'(c_q - CW'(1));
        out_row_o  = sem_pkg::ROW_W'(r_q - RW'(1));
        edge_res_o = mag_ok_q ? mag : 8'd0;
      end
      sem_pkg::SLOT_RIGHT: out_row_o = sem_pkg::ROW_W'(r_q - RW'(1));
      sem_pkg::SLOT_BOT:   out_col_o = sem_pkg::COL_W'(c_q - CW'(1));
      default:             last_o    = 1'b1;
    endcase
  end

endmodule

### rtl/sobel_edge_magnitude.sv
// sobel_edge_magnitude: top level of the streaming 3x3 Sobel edge magnitude.
// Joins sem_ctrl and sem_datapath. Depends on sem_pkg.
//
// Pixels (BGR) enter in raster order; each becomes luma, passes through a
// two-row line store and a 3x3 window, and yields the edge magnitude
// min(255, round(sqrt(gx^2+gy^2))), zero on the image border. Results lag
// one row and one column and carry their column and row; the final pixel
// of a frame flags last. One pixel is processed at a time: the transfer,
// luma, gradient, two squaring steps and 11 root steps, then four result
// slots follow, empty slots included; each stalled result adds its wait.
// The root's digit-serial unit takes the most steps. Width and height are
// register 0 and 1; the user must write them only while idle, as the block
// does not enforce this. Out-of-range sizes saturate.
module sobel_edge_magnitude #(
  parameter int unsigned MAX_WIDTH  = sem_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = sem_pkg::MAX_HEIGHT_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [sem_pkg::CFG_W-1:0] cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [7:0]                blue_i,
  input  logic [7:0]                green_i,
  input  logic [7:0]                red_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [sem_pkg::COL_W-1:0] out_col_o,
  output logic [sem_pkg::ROW_W-1:0] out_row_o,
  output logic [7:0]                edge_res_o,
  output logic                      last_o
);

  sem_pkg::sem_cmd_t cmd;
  logic [3:0]        emit_flags;

  sem_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .out_ready_i  (out_ready_i),
    .emit_flags_i (emit_flags),
    .in_ready_o   (in_ready_o),
    .out_valid_o  (out_valid_o),
    .cmd_o        (cmd)
  );

  sem_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .blue_i       (blue_i),
    .green_i      (green_i),
    .red_i        (red_i),
    .cmd_i        (cmd),
    .emit_flags_o (emit_flags),
    .out_col_o    (out_col_o),
    .out_row_o    (out_row_o),
    .edge_res_o   (edge_res_o),
    .last_o       (last_o)
  );

endmodule
